// ----- hw/rtl/spfs_pkg.sv -----
package spfs_pkg;

  localparam int unsigned IdW     = 6;
  localparam int unsigned MetricW = 32;
  localparam logic [MetricW-1:0] DistNone = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD_NODE = 2'd1,
    OP_ADD_EDGE = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIPE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_RELAX_RD,
    ST_RELAX_WT,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT
  } state_t;

endpackage

// ----- hw/rtl/shortest_path_from_source_core.sv -----
// sequence: clear wipes all 4**SW pairs (SW = ceil(log2 SLOTS), SLOTS*SLOTS for a
// power of two); add node sets the present bit; add edge reads and writes both ordered
// pairs, keeping the lower metric. query: init of every slot, then per settled node a
// scan and a relax (read, wait, relax) per slot, a last scan, then a read and a
// handshake per result; one item at a time
// reset: synchronous active-low rst_n; a pass over all 4**SW pairs marks every edge
// pair invalid before the first item is taken
module shortest_path_from_source_core #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[1:0] node_a[7:2] node_b[13:8] metric[45:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // node_index[5:0] present[6] reached[7] distance[39:8]
                                  // predecessor[45:40] has_predecessor[46]
  output logic        out_tlast
);
  import spfs_pkg::*;

  localparam int unsigned Slots = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int unsigned SW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned PW    = 2 * SW;
  localparam int unsigned Pairs = 1 << PW;
  localparam logic [SW-1:0] LastSlot = SW'(Slots - 1);

  state_t state_r, state_nxt;

  // edge memory: valid bit and metric per ordered pair
  logic [MetricW:0] pair_mem [Pairs];
  logic [MetricW:0] pair_rd_r;
  logic [PW-1:0]    pair_addr;
  logic             pair_we;
  logic [MetricW:0] pair_wd;

  // per-node state
  logic [Slots-1:0]   present_r, settled_r;
  logic [MetricW-1:0] dist_mem [Slots];
  logic [SW:0]        pred_mem [Slots];
  logic [MetricW-1:0] dist_rd_r;
  logic [SW:0]        pred_rd_r;

  logic [PW-1:0]      wipe_r;
  logic [SW-1:0]      idx_r;
  logic [SW-1:0]      src_r, a_r, b_r, u_r;
  logic [MetricW-1:0] m_r, best_r, du_r;
  logic               found_r, second_r, out_v_r;
  logic [47:0]        out_d_r;
  logic               out_l_r;

  opcode_t            op_in;
  logic [IdW-1:0]     a_in, b_in;
  logic [MetricW-1:0] m_in;
  assign op_in = opcode_t'(in_tdata[1:0]);
  assign a_in  = in_tdata[7:2];
  assign b_in  = in_tdata[13:8];
  assign m_in  = in_tdata[45:14];

  logic a_ok, b_ok;
  assign a_ok = ({26'd0, a_in} < 32'(Slots));
  assign b_ok = ({26'd0, b_in} < 32'(Slots));

  logic in_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  logic [MetricW-1:0] alt, dist_cur;
  assign alt = du_r + pair_rd_r[MetricW-1:0];
  // distance mem word for slot idx_r is dist_rd_r (registered read)
  assign dist_cur = dist_rd_r;

  logic edge_lo;
  assign edge_lo = !pair_rd_r[MetricW] || (m_r < pair_rd_r[MetricW-1:0]);

  logic relax_hit;
  assign relax_hit = pair_rd_r[MetricW] && present_r[idx_r] && !settled_r[idx_r]
                     && (alt < dist_cur);

  // last slot of a scan is compared in the pick cycle; on a tie the earlier slot is kept
  logic scan_v_r;
  logic [SW-1:0] scan_i_r;
  logic pick_hit;
  assign pick_hit = scan_v_r && present_r[scan_i_r] && !settled_r[scan_i_r]
                    && (dist_rd_r < best_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_in)
            OP_CLEAR:    state_nxt = ST_WIPE;
            OP_ADD_NODE: state_nxt = ST_IDLE;
            OP_ADD_EDGE: state_nxt = (a_ok && b_ok) ? ST_EDGE_RD : ST_IDLE;
            OP_QUERY:    state_nxt = ST_INIT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WIPE:     if (wipe_r == PW'(Pairs - 1)) state_nxt = ST_IDLE;
      ST_EDGE_RD:  state_nxt = ST_EDGE_WR;
      ST_EDGE_WR:  state_nxt = second_r ? ST_IDLE : ST_EDGE_RD;
      ST_INIT:     if (idx_r == LastSlot) state_nxt = ST_SCAN;
      ST_SCAN:     if (idx_r == LastSlot) state_nxt = ST_PICK;
      ST_PICK:     state_nxt = (found_r || pick_hit) ? ST_RELAX_RD : ST_OUT_RD;
      ST_RELAX_RD: state_nxt = ST_RELAX_WT;
      ST_RELAX_WT: state_nxt = ST_RELAX;
      ST_RELAX:    state_nxt = (idx_r == LastSlot) ? ST_SCAN : ST_RELAX_RD;
      ST_OUT_RD:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_v_r && out_tready)
          state_nxt = out_l_r ? ST_IDLE : ST_OUT_RD;
        else if (!out_v_r)
          state_nxt = ST_OUT;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // pair memory port control
  always_comb begin
    pair_we   = 1'b0;
    pair_wd   = {1'b1, m_r};
    pair_addr = {u_r, idx_r};
    unique case (state_r)
      ST_WIPE: begin
        pair_we   = 1'b1;
        pair_wd   = '0;
        pair_addr = wipe_r;
      end
      ST_EDGE_RD: pair_addr = second_r ? {b_r, a_r} : {a_r, b_r};
      ST_EDGE_WR: begin
        pair_addr = second_r ? {b_r, a_r} : {a_r, b_r};
        pair_we   = edge_lo;
      end
      default: pair_addr = {u_r, idx_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_addr] <= pair_wd;
    pair_rd_r <= pair_mem[pair_addr];
  end

  // distance and predecessor memories, one slot per cycle
  logic          dp_we;
  logic [SW-1:0] dp_wa;
  logic [MetricW-1:0] d_wd;
  logic [SW:0]   p_wd;
  always_comb begin
    dp_we = 1'b0;
    dp_wa = idx_r;
    d_wd  = DistNone;
    p_wd  = '0;
    if (state_r == ST_INIT) begin
      dp_we = 1'b1;
      // found_r holds the source range check here; a bad source reaches nothing
      d_wd  = (found_r && present_r[idx_r] && idx_r == src_r) ? '0 : DistNone;
    end else if (state_r == ST_RELAX && relax_hit) begin
      dp_we = 1'b1;
      d_wd  = alt;
      p_wd  = {1'b1, u_r};
    end
  end

  always_ff @(posedge clk) begin
    if (dp_we) begin
      dist_mem[dp_wa] <= d_wd;
      pred_mem[dp_wa] <= p_wd;
    end
    dist_rd_r <= dist_mem[idx_r];
    pred_rd_r <= pred_mem[idx_r];
  end

  // scan compare uses the distance read of the previous cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_WIPE;
      wipe_r    <= '0;
      present_r <= '0;
      settled_r <= '0;
      idx_r     <= '0;
      found_r   <= 1'b0;
      second_r  <= 1'b0;
      out_v_r   <= 1'b0;
      scan_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          idx_r    <= '0;
          second_r <= 1'b0;
          if (in_fire) begin
            a_r   <= a_in[SW-1:0];
            b_r   <= b_in[SW-1:0];
            m_r   <= m_in;
            src_r <= a_in[SW-1:0];
            unique case (op_in)
              OP_CLEAR: begin
                present_r <= '0;
                wipe_r    <= '0;
              end
              OP_ADD_NODE: if (a_ok) present_r[a_in[SW-1:0]] <= 1'b1;
              OP_QUERY: begin
                settled_r <= '0;
                found_r   <= a_ok;
              end
              default: ;
            endcase
          end
        end
        ST_WIPE: wipe_r <= wipe_r + PW'(1);
        ST_EDGE_WR: second_r <= 1'b1;
        ST_INIT: begin
          idx_r    <= (idx_r == LastSlot) ? '0 : idx_r + SW'(1);
          best_r   <= DistNone;
          scan_v_r <= 1'b0;
          if (idx_r == LastSlot) found_r <= 1'b0;
        end
        ST_SCAN: begin
          scan_i_r <= idx_r;
          scan_v_r <= 1'b1;
          idx_r    <= (idx_r == LastSlot) ? '0 : idx_r + SW'(1);
          if (scan_v_r && present_r[scan_i_r] && !settled_r[scan_i_r]
              && dist_rd_r < best_r) begin
            best_r  <= dist_rd_r;
            u_r     <= scan_i_r;
            found_r <= 1'b1;
          end
        end
        ST_PICK: begin
          // last slot of the scan is compared here
          scan_v_r <= 1'b0;
          if (pick_hit) begin
            u_r <= scan_i_r;
            du_r <= dist_rd_r;
            settled_r[scan_i_r] <= 1'b1;
            found_r <= 1'b1;
          end else begin
            du_r <= best_r;
            if (found_r) settled_r[u_r] <= 1'b1;
          end
          idx_r <= '0;
        end
        ST_RELAX: begin
          idx_r <= (idx_r == LastSlot) ? '0 : idx_r + SW'(1);
          if (idx_r == LastSlot) begin
            found_r <= 1'b0;
            best_r  <= DistNone;
          end
        end
        ST_OUT: begin
          if (!out_v_r) begin
            out_v_r <= 1'b1;
            out_l_r <= (idx_r == LastSlot);
            out_d_r <= {1'b0,
                        settled_r[idx_r] && pred_rd_r[SW],
                        (settled_r[idx_r] && pred_rd_r[SW]) ?
                          IdW'(pred_rd_r[SW-1:0]) : IdW'(0),
                        settled_r[idx_r] ? dist_rd_r : DistNone,
                        settled_r[idx_r], present_r[idx_r], IdW'(idx_r)};
          end else if (out_tready) begin
            out_v_r <= 1'b0;
            idx_r   <= idx_r + SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;

endmodule
